// ===== sv/aes_pkg.sv =====
package aes_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned EncW  = 2;

  localparam logic [EncW-1:0] ENC_IDENTITY = 2'd0;
  localparam logic [EncW-1:0] ENC_GZIP     = 2'd1;
  localparam logic [EncW-1:0] ENC_BROTLI   = 2'd2;

  // entry phases
  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_NAME  = 2'd1;
  localparam logic [1:0] PH_PARAM = 2'd2;

  // q parameter phases
  localparam logic [2:0] Q_SEARCH = 3'd0;
  localparam logic [2:0] Q_GOTQ   = 3'd1;
  localparam logic [2:0] Q_SKIPWS = 3'd2;
  localparam logic [2:0] Q_AFTER0 = 3'd3;
  localparam logic [2:0] Q_SCAN   = 3'd4;
  localparam logic [2:0] Q_DONE   = 3'd5;

  // name matcher mismatch codes
  localparam logic [1:0] BR_MISS = 2'd3;
  localparam logic [2:0] GZ_MISS = 3'd7;
  localparam logic [1:0] ST_MISS = 2'd3;

  // token bits in the decided/accepted masks
  localparam logic [2:0] TOK_BR   = 3'b001;
  localparam logic [2:0] TOK_GZIP = 3'b010;
  localparam logic [2:0] TOK_STAR = 3'b100;

  // one header word as it moves from the input register into the parser
  typedef struct packed {
    logic [ByteW-1:0] header_byte;
    logic             has_byte;
    logic             last;
  } aes_item_t;

endpackage

// ===== sv/aes_parse.sv =====
module aes_parse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  aes_pkg::aes_item_t            item,
  output logic [aes_pkg::EncW-1:0]      encoding
);

  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;

  logic [1:0] entry_phase,          entry_phase_next;
  logic [1:0] br_name_progress,     br_name_progress_next;
  logic [2:0] gzip_name_progress,   gzip_name_progress_next;
  logic [1:0] star_name_progress,   star_name_progress_next;
  logic       name_trailing_space,  name_trailing_space_next;
  logic [2:0] qparam_phase,         qparam_phase_next;
  logic       qvalue_is_zero,       qvalue_is_zero_next;
  logic [2:0] token_decided,        token_decided_next;
  logic [2:0] token_accepted,       token_accepted_next;
  logic [1:0] br_anywhere_progress, br_anywhere_progress_next;
  logic [2:0] gzip_anywhere_progress, gzip_anywhere_progress_next;
  logic [1:0] seen_anywhere,        seen_anywhere_next;

  function automatic logic [7:0] gz_letter(input logic [1:0] idx);
    case (idx)
      2'd0:    gz_letter = CH_G;
      2'd1:    gz_letter = CH_Z;
      2'd2:    gz_letter = CH_I;
      default: gz_letter = CH_P;
    endcase
  endfunction

  logic [7:0] raw;
  logic [7:0] c;
  logic       is_ws;
  logic       do_close;
  logic [2:0] tok_bit;
  logic       refused;
  logic       br_ok;
  logic       gz_ok;
  logic       st_ok;

  assign raw   = item.header_byte;
  assign c     = (raw >= 8'h41 && raw <= 8'h5a) ? raw + 8'd32 : raw;
  assign is_ws = (raw == CH_SPACE) || (raw == CH_TAB);

  always_comb begin
    entry_phase_next            = entry_phase;
    br_name_progress_next       = br_name_progress;
    gzip_name_progress_next     = gzip_name_progress;
    star_name_progress_next     = star_name_progress;
    name_trailing_space_next    = name_trailing_space;
    qparam_phase_next           = qparam_phase;
    qvalue_is_zero_next         = qvalue_is_zero;
    token_decided_next          = token_decided;
    token_accepted_next         = token_accepted;
    br_anywhere_progress_next   = br_anywhere_progress;
    gzip_anywhere_progress_next = gzip_anywhere_progress;
    seen_anywhere_next          = seen_anywhere;
    do_close                    = 1'b0;
    tok_bit                     = 3'b000;
    refused                     = 1'b0;
    encoding                    = aes_pkg::ENC_IDENTITY;
    br_ok                       = 1'b0;
    gz_ok                       = 1'b0;
    st_ok                       = 1'b0;

    if (item.has_byte) begin
      // substring tracking over the whole header
      if (br_anywhere_progress == 2'd1 && c == CH_R) begin
        seen_anywhere_next[0]     = 1'b1;
        br_anywhere_progress_next = 2'd0;
      end else begin
        br_anywhere_progress_next = (c == CH_B) ? 2'd1 : 2'd0;
      end
      if (gzip_anywhere_progress < 3'd4 && c == gz_letter(gzip_anywhere_progress[1:0])) begin
        if (gzip_anywhere_progress == 3'd3) begin
          seen_anywhere_next[1]       = 1'b1;
          gzip_anywhere_progress_next = 3'd0;
        end else begin
          gzip_anywhere_progress_next = gzip_anywhere_progress + 3'd1;
        end
      end else begin
        gzip_anywhere_progress_next = (c == CH_G) ? 3'd1 : 3'd0;
      end

      if (raw == CH_COMMA) begin
        do_close = 1'b1;
      end else if (!(entry_phase == aes_pkg::PH_LEAD && is_ws)) begin
        if (entry_phase == aes_pkg::PH_LEAD || entry_phase == aes_pkg::PH_NAME) begin
          entry_phase_next = aes_pkg::PH_NAME;
          if (raw == CH_SEMI) begin
            entry_phase_next = aes_pkg::PH_PARAM;
          end else if (is_ws) begin
            name_trailing_space_next = 1'b1;
          end else if (name_trailing_space) begin
            br_name_progress_next   = aes_pkg::BR_MISS;
            gzip_name_progress_next = aes_pkg::GZ_MISS;
            star_name_progress_next = aes_pkg::ST_MISS;
          end else begin
            br_name_progress_next = (br_name_progress < 2'd2 &&
                c == ((br_name_progress == 2'd0) ? CH_B : CH_R)) ?
                br_name_progress + 2'd1 : aes_pkg::BR_MISS;
            gzip_name_progress_next = (gzip_name_progress < 3'd4 &&
                c == gz_letter(gzip_name_progress[1:0])) ?
                gzip_name_progress + 3'd1 : aes_pkg::GZ_MISS;
            star_name_progress_next = (star_name_progress == 2'd0 && c == CH_STAR) ?
                2'd1 : aes_pkg::ST_MISS;
          end
        end else begin
          case (qparam_phase)
            aes_pkg::Q_SEARCH: begin
              if (c == CH_Q) qparam_phase_next = aes_pkg::Q_GOTQ;
            end
            aes_pkg::Q_GOTQ: begin
              if (c == CH_EQ) qparam_phase_next = aes_pkg::Q_SKIPWS;
              else if (c != CH_Q) qparam_phase_next = aes_pkg::Q_SEARCH;
            end
            aes_pkg::Q_SKIPWS: begin
              if (!is_ws) begin
                if (raw == CH_ZERO) begin
                  qparam_phase_next = aes_pkg::Q_AFTER0;
                end else begin
                  qparam_phase_next   = aes_pkg::Q_DONE;
                  qvalue_is_zero_next = 1'b0;
                end
              end
            end
            aes_pkg::Q_AFTER0: begin
              if (raw == CH_DOT) begin
                qparam_phase_next = aes_pkg::Q_SCAN;
              end else begin
                qparam_phase_next   = aes_pkg::Q_DONE;
                qvalue_is_zero_next = (raw == CH_SPACE);
              end
            end
            aes_pkg::Q_SCAN: begin
              if (raw == CH_SPACE) begin
                qparam_phase_next   = aes_pkg::Q_DONE;
                qvalue_is_zero_next = 1'b1;
              end else if (raw != CH_ZERO && raw != CH_DOT) begin
                qparam_phase_next   = aes_pkg::Q_DONE;
                qvalue_is_zero_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
    end

    // a comma closes the entry as it stood; the end of header closes what is left
    if (do_close) begin
      if (br_name_progress == 2'd2)        tok_bit = aes_pkg::TOK_BR;
      else if (gzip_name_progress == 3'd4) tok_bit = aes_pkg::TOK_GZIP;
      else if (star_name_progress == 2'd1) tok_bit = aes_pkg::TOK_STAR;
      refused = (qparam_phase == aes_pkg::Q_AFTER0) || (qparam_phase == aes_pkg::Q_SCAN) ||
                (qparam_phase == aes_pkg::Q_DONE && qvalue_is_zero);
    end else if (item.last) begin
      if (br_name_progress_next == 2'd2)        tok_bit = aes_pkg::TOK_BR;
      else if (gzip_name_progress_next == 3'd4) tok_bit = aes_pkg::TOK_GZIP;
      else if (star_name_progress_next == 2'd1) tok_bit = aes_pkg::TOK_STAR;
      refused = (qparam_phase_next == aes_pkg::Q_AFTER0) ||
                (qparam_phase_next == aes_pkg::Q_SCAN) ||
                (qparam_phase_next == aes_pkg::Q_DONE && qvalue_is_zero_next);
    end
    if ((tok_bit & token_decided) == 3'b000) begin
      token_decided_next = token_decided | tok_bit;
      if (!refused) token_accepted_next = token_accepted | tok_bit;
    end
    if (do_close) begin
      entry_phase_next         = aes_pkg::PH_LEAD;
      br_name_progress_next    = 2'd0;
      gzip_name_progress_next  = 3'd0;
      star_name_progress_next  = 2'd0;
      name_trailing_space_next = 1'b0;
      qparam_phase_next        = aes_pkg::Q_SEARCH;
      qvalue_is_zero_next      = 1'b0;
    end

    br_ok = token_accepted_next[0];
    gz_ok = token_accepted_next[1];
    st_ok = token_accepted_next[2];
    if (br_ok) begin
      encoding = aes_pkg::ENC_BROTLI;
    end else if (st_ok) begin
      // wildcard covers tokens that never appear in the header
      if (!seen_anywhere_next[0])      encoding = aes_pkg::ENC_BROTLI;
      else if (gz_ok)                  encoding = aes_pkg::ENC_GZIP;
      else if (!seen_anywhere_next[1]) encoding = aes_pkg::ENC_GZIP;
      else                             encoding = aes_pkg::ENC_IDENTITY;
    end else if (gz_ok) begin
      encoding = aes_pkg::ENC_GZIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      entry_phase            <= aes_pkg::PH_LEAD;
      br_name_progress       <= 2'd0;
      gzip_name_progress     <= 3'd0;
      star_name_progress     <= 2'd0;
      name_trailing_space    <= 1'b0;
      qparam_phase           <= aes_pkg::Q_SEARCH;
      qvalue_is_zero         <= 1'b0;
      token_decided          <= 3'b000;
      token_accepted         <= 3'b000;
      br_anywhere_progress   <= 2'd0;
      gzip_anywhere_progress <= 3'd0;
      seen_anywhere          <= 2'b00;
    end else if (step) begin
      entry_phase            <= entry_phase_next;
      br_name_progress       <= br_name_progress_next;
      gzip_name_progress     <= gzip_name_progress_next;
      star_name_progress     <= star_name_progress_next;
      name_trailing_space    <= name_trailing_space_next;
      qparam_phase           <= qparam_phase_next;
      qvalue_is_zero         <= qvalue_is_zero_next;
      token_decided          <= token_decided_next;
      token_accepted         <= token_accepted_next;
      br_anywhere_progress   <= br_anywhere_progress_next;
      gzip_anywhere_progress <= gzip_anywhere_progress_next;
      seen_anywhere          <= seen_anywhere_next;
    end
  end

endmodule

// ===== sv/accept_encoding_selector.sv =====
// a last word passes from the input register through the parser into the result register, then shows on m_axis
// throughput: one header word per cycle; a result waiting on m_axis_tready holds a later last word
//   and the words behind it in the input register, earlier words keep flowing into the parser
// parse state is updated once per word by the parser between input and result registers
// reset (rst, synchronous, active high) empties both registers and clears all parse state
module accept_encoding_selector (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] header_byte
  input  logic       s_axis_tuser,   // [0] has_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [1:0] encoding, [7:2] zero
);

  logic                       in_valid;
  aes_pkg::aes_item_t         in_item;
  logic                       out_free;
  logic                       step;
  logic [aes_pkg::EncW-1:0]   encoding;
  logic [aes_pkg::EncW-1:0]   enc_reg;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  // a last word needs the result register free before it can leave the input register
  assign step          = in_valid && (!in_item.last || out_free);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.header_byte <= s_axis_tdata;
      in_item.has_byte    <= s_axis_tuser;
      in_item.last        <= s_axis_tlast;
    end
  end

  aes_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (in_item),
    .encoding (encoding)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step && in_item.last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_item.last) begin
      enc_reg <= encoding;
    end
  end

  assign m_axis_tdata = {{(8 - aes_pkg::EncW){1'b0}}, enc_reg};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic [15:0] BR_TEXT   = "br";
  localparam logic [31:0] GZIP_TEXT = "gzip";

  localparam int NUM_PHASES  = 4;
  localparam int PHASE_WORDS = 1850 / NUM_PHASES;

  int send_idle_by_phase[NUM_PHASES] = '{0, 59, 0, 12};
  int recv_stall_by_phase[NUM_PHASES] = '{0, 0, 59, 12};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] header_byte
  logic       s_axis_tuser = 1'b0;    // [0] has_byte
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [1:0] encoding, [7:2] zero

  accept_encoding_selector i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  aes_pkg::aes_item_t pending_words[$];
  logic [1:0] expected_enc[$];
  logic [7:0] hdr_bytes[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_queued = 0;
  int words_sent = 0;
  int headers_done = 0;
  int error_count = 0;
  int enc_count[3] = '{0, 0, 0};

  // ---------------------------------------------------------------- negotiation state
  logic [1:0]    ent_phase;
  logic [1:0]    br_prog;
  logic [2:0]    gzip_prog;
  logic [1:0]    star_prog;
  logic          name_blank;
  logic [2:0]    q_phase;
  logic          q_zero;
  logic [2:0]    tok_decided;
  logic [2:0]    tok_accepted;
  logic [1:0]    br_scan;
  logic [2:0]    gzip_scan;
  logic [1:0]    seen_text;   // [0] br, [1] gzip anywhere in the header

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == " " || c == "\t";
  endfunction

  function automatic logic [7:0] gzip_letter(input logic [2:0] k);
    return GZIP_TEXT[31 - 8 * k -: 8];
  endfunction

  function automatic logic [7:0] br_letter(input logic [1:0] k);
    return BR_TEXT[15 - 8 * k -: 8];
  endfunction

  function automatic void clear_entry_state();
    ent_phase  = aes_pkg::PH_LEAD;
    br_prog    = 2'd0;
    gzip_prog  = 3'd0;
    star_prog  = 2'd0;
    name_blank = 1'b0;
    q_phase    = aes_pkg::Q_SEARCH;
    q_zero     = 1'b0;
  endfunction

  function automatic void clear_header_state();
    clear_entry_state();
    tok_decided  = 3'b000;
    tok_accepted = 3'b000;
    br_scan      = 2'd0;
    gzip_scan    = 3'd0;
    seen_text    = 2'b00;
  endfunction

  function automatic void close_entry_state();
    logic [2:0] tok;
    bit         refused;
    tok = 3'b000;
    if (br_prog == 2'd2) tok = aes_pkg::TOK_BR;
    else if (gzip_prog == 3'd4) tok = aes_pkg::TOK_GZIP;
    else if (star_prog == 2'd1) tok = aes_pkg::TOK_STAR;
    refused = q_phase == aes_pkg::Q_AFTER0 || q_phase == aes_pkg::Q_SCAN ||
              (q_phase == aes_pkg::Q_DONE && q_zero);
    if (tok != 3'b000 && (tok_decided & tok) == 3'b000) begin
      tok_decided = tok_decided | tok;
      if (!refused) tok_accepted = tok_accepted | tok;
    end
    clear_entry_state();
  endfunction

  // substring search for br and gzip over the whole header
  function automatic void scan_anywhere(input logic [7:0] c);
    if (br_scan == 2'd1 && c == br_letter(2'd1)) begin
      seen_text[0] = 1'b1;
      br_scan = 2'd0;
    end else begin
      br_scan = (c == br_letter(2'd0)) ? 2'd1 : 2'd0;
    end
    if (gzip_scan < 3'd4 && c == gzip_letter(gzip_scan)) begin
      gzip_scan = gzip_scan + 3'd1;
      if (gzip_scan == 3'd4) begin
        seen_text[1] = 1'b1;
        gzip_scan = 3'd0;
      end
    end else begin
      gzip_scan = (c == gzip_letter(3'd0)) ? 3'd1 : 3'd0;
    end
  endfunction

  function automatic void name_letter(input logic [7:0] c);
    if (name_blank) begin
      // blank inside the name spoils every match
      br_prog   = aes_pkg::BR_MISS;
      gzip_prog = aes_pkg::GZ_MISS;
      star_prog = aes_pkg::ST_MISS;
      return;
    end
    if (br_prog < 2'd2 && c == br_letter(br_prog)) br_prog = br_prog + 2'd1;
    else br_prog = aes_pkg::BR_MISS;
    if (gzip_prog < 3'd4 && c == gzip_letter(gzip_prog)) gzip_prog = gzip_prog + 3'd1;
    else gzip_prog = aes_pkg::GZ_MISS;
    if (star_prog == 2'd0 && c == "*") star_prog = 2'd1;
    else star_prog = aes_pkg::ST_MISS;
  endfunction

  function automatic void param_letter(input logic [7:0] raw, input logic [7:0] c);
    case (q_phase)
      aes_pkg::Q_SEARCH: begin
        if (c == "q") q_phase = aes_pkg::Q_GOTQ;
      end
      aes_pkg::Q_GOTQ: begin
        if (c == "=") q_phase = aes_pkg::Q_SKIPWS;
        else if (c != "q") q_phase = aes_pkg::Q_SEARCH;
      end
      aes_pkg::Q_SKIPWS: begin
        if (!is_blank(raw)) begin
          if (raw == "0") begin
            q_phase = aes_pkg::Q_AFTER0;
          end else begin
            q_phase = aes_pkg::Q_DONE;
            q_zero = 1'b0;
          end
        end
      end
      aes_pkg::Q_AFTER0: begin
        if (raw == ".") begin
          q_phase = aes_pkg::Q_SCAN;
        end else begin
          q_phase = aes_pkg::Q_DONE;
          q_zero = raw == " ";
        end
      end
      aes_pkg::Q_SCAN: begin
        if (raw == " ") begin
          q_phase = aes_pkg::Q_DONE;
          q_zero = 1'b1;
        end else if (raw != "0" && raw != ".") begin
          q_phase = aes_pkg::Q_DONE;
          q_zero = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void consume_byte(input logic [7:0] raw);
    logic [7:0] c;
    c = fold_case(raw);
    scan_anywhere(c);
    if (raw == ",") begin
      close_entry_state();
      return;
    end
    if (ent_phase == aes_pkg::PH_LEAD) begin
      if (is_blank(raw)) return;
      ent_phase = aes_pkg::PH_NAME;
    end
    if (ent_phase == aes_pkg::PH_NAME) begin
      if (raw == ";") ent_phase = aes_pkg::PH_PARAM;
      else if (is_blank(raw)) name_blank = 1'b1;
      else name_letter(c);
      return;
    end
    param_letter(raw, c);
  endfunction

  function automatic logic [1:0] pick_encoding();
    if (tok_accepted[0]) return aes_pkg::ENC_BROTLI;
    if (tok_accepted[2]) begin
      // wildcard only covers tokens not spelled anywhere
      if (!seen_text[0]) return aes_pkg::ENC_BROTLI;
      if (tok_accepted[1]) return aes_pkg::ENC_GZIP;
      if (!seen_text[1]) return aes_pkg::ENC_GZIP;
      return aes_pkg::ENC_IDENTITY;
    end
    if (tok_accepted[1]) return aes_pkg::ENC_GZIP;
    return aes_pkg::ENC_IDENTITY;
  endfunction

  function automatic void predict_word(input logic [7:0] b, input logic has, input logic fin);
    if (has) consume_byte(b);
    if (fin) begin
      close_entry_state();
      expected_enc.push_back(pick_encoding());
      clear_header_state();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  function automatic void push_word(input logic [7:0] b, input logic has, input logic fin);
    aes_pkg::aes_item_t w;
    w.header_byte = b;
    w.has_byte    = has;
    w.last        = fin;
    pending_words.push_back(w);
    if (has || fin) words_queued++;
  endfunction

  function automatic void push_text(input string s, input bit last_on_end);
    for (int i = 0; i < s.len(); i++)
      push_word(s[i], 1'b1, last_on_end && i == s.len() - 1);
  endfunction

  function automatic logic [7:0] noise_byte();
    string specials;
    specials = " \t,;q=0.*bgzipBRQ";
    if ($urandom_range(1) == 0) return 8'($urandom_range(255));
    return specials[$urandom_range(specials.len() - 1)];
  endfunction

  function automatic void add_text(input string s, input bit mixed_case);
    logic [7:0] b;
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      if (mixed_case && b >= "a" && b <= "z" && $urandom_range(9) < 3) b = b - 8'd32;
      hdr_bytes.push_back(b);
    end
  endfunction

  function automatic void add_blanks();
    repeat ($urandom_range(3) == 0 ? $urandom_range(2, 1) : 0)
      hdr_bytes.push_back($urandom_range(1) ? " " : "\t");
  endfunction

  function automatic string pick_name();
    case ($urandom_range(15))
      0, 1, 2:  return "br";
      3, 4, 5:  return "gzip";
      6, 7:     return "*";
      8:        return "identity";
      9:        return "deflate";
      10:       return "b";
      11:       return "gz";
      12:       return "gzipx";
      13:       return "brr";
      14:       return "**";
      default:  return "";
    endcase
  endfunction

  function automatic string pick_qvalue();
    case ($urandom_range(15))
      0:       return "0";
      1:       return "0.0";
      2:       return "0.000";
      3:       return "00";
      4:       return "0.5";
      5:       return "1";
      6:       return "1.0";
      7:       return "0 ";
      8:       return "0\t";
      9:       return " 0";
      10:      return "\t0";
      11:      return "0.0x";
      12:      return "0.9";
      13:      return "0. ";
      14:      return "0.0 1";
      default: return "";
    endcase
  endfunction

  function automatic void add_param();
    case ($urandom_range(9))
      6:       add_text("level=1", 1'b1);
      7:       add_text("qq=0", 1'b1);
      8:       add_text("q=0;q=1", 1'b1);
      9:       add_text("aq=0", 1'b1);
      default: begin
        add_text("q=", 1'b1);
        add_text(pick_qvalue(), 1'b0);
      end
    endcase
    add_blanks();
  endfunction

  // mostly well-formed headers with random content, some noise and empty ones
  function automatic void make_header();
    int kind;
    int n_ent;
    int n_par;
    hdr_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 6) return;
    if (kind < 16) begin
      repeat ($urandom_range(12, 1)) hdr_bytes.push_back(noise_byte());
      return;
    end
    n_ent = $urandom_range(4, 1);
    for (int e = 0; e < n_ent; e++) begin
      if (e != 0) hdr_bytes.push_back(",");
      add_blanks();
      add_text(pick_name(), 1'b1);
      if ($urandom_range(9) == 0) begin
        hdr_bytes.push_back(" ");
        add_text(pick_name(), 1'b1);
      end
      add_blanks();
      n_par = ($urandom_range(99) < 55) ? $urandom_range(2, 1) : 0;
      repeat (n_par) begin
        hdr_bytes.push_back(";");
        add_blanks();
        add_param();
      end
    end
    if ($urandom_range(9) == 0) hdr_bytes.push_back(",");
    if ($urandom_range(9) == 0)
      hdr_bytes[$urandom_range(hdr_bytes.size() - 1)] = noise_byte();
  endfunction

  function automatic void queue_header();
    bit last_alone;
    last_alone = hdr_bytes.size() == 0 || $urandom_range(3) == 0;
    foreach (hdr_bytes[i]) begin
      // word with no byte in the middle of a header
      if ($urandom_range(19) == 0) push_word(8'($urandom_range(255)), 1'b0, 1'b0);
      push_word(hdr_bytes[i], 1'b1, !last_alone && i == hdr_bytes.size() - 1);
    end
    if (last_alone) push_word(8'($urandom_range(255)), 1'b0, 1'b1);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive_words
    aes_pkg::aes_item_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        words_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= w.header_byte;
          s_axis_tuser  <= w.has_byte;
          s_axis_tlast  <= w.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : check_results
    logic [1:0] want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_enc.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
        end else begin
          want = expected_enc.pop_front();
          if (m_axis_tdata[1:0] != want)
            report_mismatch($sformatf("header %0d encoding %0d, want %0d",
                                      headers_done, m_axis_tdata[1:0], want));
          if (m_axis_tdata[7:2] != 6'd0)
            report_mismatch($sformatf("header %0d pad bits %b not zero",
                                      headers_done, m_axis_tdata[7:2]));
          if (want <= aes_pkg::ENC_BROTLI) enc_count[want]++;
        end
        headers_done++;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int goal;
    clear_header_state();

    // empty header
    push_word(8'h00, 1'b0, 1'b1);
    // leading tab, mixed case br refused by q=0
    push_text("\tbR;q=0", 1'b1);
    // wildcard refused with trailing blank in value, gzip accepted, no-byte words
    push_text("*;q=0 ,", 1'b0);
    push_word(8'hA5, 1'b0, 1'b0);
    push_text("GZIP", 1'b0);
    push_word(8'h5A, 1'b0, 1'b1);
    // byte extremes
    push_word(8'hFF, 1'b1, 1'b0);
    push_word(8'h00, 1'b1, 1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      @(negedge clk);
      send_idle_pct  = send_idle_by_phase[ph];
      recv_stall_pct = recv_stall_by_phase[ph];
      goal = words_queued + PHASE_WORDS;
      while (words_queued < goal) begin
        make_header();
        queue_header();
      end
      while (pending_words.size() != 0 || s_axis_tvalid) @(negedge clk);
    end

    while (expected_enc.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("sent %0d header words, %0d headers checked over %0d idle/stall phases",
             words_sent, headers_done, NUM_PHASES);
    $display("chosen: identity %0d, gzip %0d, brotli %0d",
             enc_count[0], enc_count[1], enc_count[2]);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_enc.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/aes_pkg.sv
sv/aes_parse.sv
sv/accept_encoding_selector.sv
dv/tb.sv
